>>> rtl/core/sec2date_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sec2date_pkg: shared constants for the seconds-to-calendar-date core
// Widths, reciprocal multipliers for the constant divisions and the
// cumulative month-length tables for common and leap years.
// ----------------------------------------------------------------------------
package sec2date_pkg;

	// Input width in bits.
	localparam int SECONDS_WIDTH = 36;

	// 86400 seconds per day splits into 675 times 2^7.
	localparam int SECS_PER_DAY  = 86400;
	localparam int DAY_LO_BITS   = 7;
	localparam int DAY_ODD_DIV   = 675;
	localparam int SEC_HI_WIDTH  = SECONDS_WIDTH - DAY_LO_BITS;

	localparam longint unsigned SECS_MAX = (64'd1 << SECONDS_WIDTH) - 64'd1;
	localparam longint unsigned DAYS_MAX = SECS_MAX / SECS_PER_DAY;
	localparam int DAYS_WIDTH = $clog2(DAYS_MAX + 64'd1);

	// Floor reciprocal of 675; the estimate is the quotient or one below it.
	localparam int DIV675_SHIFT = SEC_HI_WIDTH + 10;
	localparam longint unsigned DIV675_MULT = (64'd1 << DIV675_SHIFT) / DAY_ODD_DIV;
	localparam int DIV675_MWIDTH = $clog2(DIV675_MULT + 64'd1);
	localparam int DIV675_PWIDTH = SEC_HI_WIDTH + DIV675_MWIDTH;
	// Remainder before correction lies below twice 675.
	localparam int DREM_WIDTH = 11;

	// Seconds of the day.
	localparam int TOD_WIDTH  = 17;
	localparam int HOUR_SECS  = 3600;
	localparam int MIN_SECS   = 60;
	localparam int RSEC_WIDTH = 12;

	// Exact division of the time of day by 3600 and of the rest by 60.
	localparam int DIV3600_SHIFT = TOD_WIDTH + 12;
	localparam longint unsigned DIV3600_MULT =
		((64'd1 << DIV3600_SHIFT) + HOUR_SECS - 1) / HOUR_SECS;
	localparam int DIV3600_MWIDTH = $clog2(DIV3600_MULT + 64'd1);
	localparam int DIV3600_PWIDTH = TOD_WIDTH + DIV3600_MWIDTH;

	localparam int DIV60_SHIFT = RSEC_WIDTH + 6;
	localparam longint unsigned DIV60_MULT =
		((64'd1 << DIV60_SHIFT) + MIN_SECS - 1) / MIN_SECS;
	localparam int DIV60_MWIDTH = $clog2(DIV60_MULT + 64'd1);
	localparam int DIV60_PWIDTH = RSEC_WIDTH + DIV60_MWIDTH;

	// Year estimate: days * 400 / 146097 from below, off by at most one.
	localparam int GREG_CYCLE_DAYS = 146097;
	localparam int GREG_CYCLE_YEARS = 400;
	localparam longint unsigned YEST_MULT =
		((64'd1 << DAYS_WIDTH) * GREG_CYCLE_YEARS) / GREG_CYCLE_DAYS;
	localparam int YEST_MWIDTH = $clog2(YEST_MULT + 64'd1);
	localparam int YEST_PWIDTH = DAYS_WIDTH + YEST_MWIDTH;

	localparam int YEAR_WIDTH = $clog2(DAYS_MAX / 365 + 64'd16);
	localparam int YOFF_WIDTH = YEAR_WIDTH + 1;
	// Offset that turns years since the epoch into the century count.
	localparam int YEAR_OFFS  = 11;
	localparam int CENTURY    = 100;

	// Exact division by 100 of years since the epoch plus the offset.
	localparam int DIV100_SHIFT = YOFF_WIDTH + 7;
	localparam longint unsigned DIV100_MULT =
		((64'd1 << DIV100_SHIFT) + CENTURY - 1) / CENTURY;
	localparam int DIV100_MWIDTH = $clog2(DIV100_MULT + 64'd1);
	localparam int DIV100_PWIDTH = YOFF_WIDTH + DIV100_MWIDTH;

	// First-day index of a year, with headroom above the largest day count.
	localparam int YS_WIDTH   = DAYS_WIDTH + 1;
	localparam int DAYS_PER_YEAR = 365;
	localparam int NUM_CAND   = 4;

	localparam int DOY_WIDTH  = 9;
	localparam int YEAR_BASE  = 2012;
	localparam int YEAR_OUT_WIDTH = 13;

	typedef logic [DOY_WIDTH-1:0] cum_tab_t [13];

	localparam cum_tab_t CUM_COMMON = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
	localparam cum_tab_t CUM_LEAP = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

	// Days before the first of month index idx (0 is January).
	function automatic logic [DOY_WIDTH-1:0] cum_days(input logic leap,
		input logic [3:0] idx);
		return leap ? CUM_LEAP[idx] : CUM_COMMON[idx];
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/seconds_to_calendar_date_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_core: epoch seconds to Gregorian date and time
// Ten-stage pipeline that turns seconds since 2012-01-01 00:00:00 into
// year, month, day of month, hour, minute and second.
// ----------------------------------------------------------------------------
// The core takes one beat of epoch_seconds (seconds since 2012-01-01
// 00:00:00) and returns one beat with the Gregorian year, month, day of
// month, hour, minute and second. It holds no state besides the pipeline,
// so results come out in the order the inputs went in. The datapath is ten
// register stages deep. A new input can be taken in every cycle, so the
// sustained rate is one beat per clock while out_ready stays high. Each
// stage holds its own valid bit and loads whenever it is empty or its
// content moves on, so bubbles are squeezed out. in_ready is formed
// combinationally from out_ready and the valid bits of all ten stages, so
// a full pipeline stops taking inputs in the same cycle in which out_ready
// goes low. The last stage is the output register.
// Years above 8191, which only occur with a wider input, wrap in the
// 13-bit year field.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [sec2date_pkg::SECONDS_WIDTH-1:0]   epoch_seconds,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [sec2date_pkg::YEAR_OUT_WIDTH-1:0]  year,
	output logic [3:0]                               month,
	output logic [4:0]                               day_of_month,
	output logic [4:0]                               hour,
	output logic [5:0]                               minute,
	output logic [5:0]                               second
);
	import sec2date_pkg::*;

	// Valid bits and stage advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9, adv10;

	// A stage may load when it is empty or when its content moves on.
	assign adv10 = !v_s10 || out_ready;
	assign adv9  = !v_s9  || adv10;
	assign adv8  = !v_s8  || adv9;
	assign adv7  = !v_s7  || adv8;
	assign adv6  = !v_s6  || adv7;
	assign adv5  = !v_s5  || adv6;
	assign adv4  = !v_s4  || adv5;
	assign adv3  = !v_s3  || adv4;
	assign adv2  = !v_s2  || adv3;
	assign adv1  = !v_s1  || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (adv1)  v_s1  <= in_valid;
			if (adv2)  v_s2  <= v_s1;
			if (adv3)  v_s3  <= v_s2;
			if (adv4)  v_s4  <= v_s3;
			if (adv5)  v_s5  <= v_s4;
			if (adv6)  v_s6  <= v_s5;
			if (adv7)  v_s7  <= v_s6;
			if (adv8)  v_s8  <= v_s7;
			if (adv9)  v_s9  <= v_s8;
			if (adv10) v_s10 <= v_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the low seven bits of the seconds are the low bits of the
	// time of day; the upper part is multiplied by the reciprocal of 675.
	// ------------------------------------------------------------------
	logic [SEC_HI_WIDTH-1:0]  shi_s1;
	logic [DAY_LO_BITS-1:0]   slo_s1;
	logic [DIV675_PWIDTH-1:0] dprod_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			shi_s1   <= epoch_seconds[SECONDS_WIDTH-1:DAY_LO_BITS];
			slo_s1   <= epoch_seconds[DAY_LO_BITS-1:0];
			dprod_s1 <= DIV675_PWIDTH'(epoch_seconds[SECONDS_WIDTH-1:DAY_LO_BITS])
				* DIV675_PWIDTH'(DIV675_MULT);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: day estimate and its remainder, which is below 2 * 675.
	// The remainder is formed modulo 2^11, which is enough to hold it.
	// ------------------------------------------------------------------
	logic [DAYS_WIDTH-1:0]  qest_c;
	logic [DREM_WIDTH-1:0]  drem_c;
	logic [DAYS_WIDTH-1:0]  qest_s2;
	logic [DREM_WIDTH-1:0]  drem_s2;
	logic [DAY_LO_BITS-1:0] slo_s2;

	always_comb begin
		qest_c = DAYS_WIDTH'(dprod_s1 >> DIV675_SHIFT);
		drem_c = DREM_WIDTH'(shi_s1) - DREM_WIDTH'(qest_c) * DREM_WIDTH'(DAY_ODD_DIV);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			qest_s2 <= qest_c;
			drem_s2 <= drem_c;
			slo_s2  <= slo_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: one correction step gives the exact day count and the
	// seconds of the day.
	// ------------------------------------------------------------------
	logic                  dfix_c;
	logic [DREM_WIDTH-1:0] rfix_c;
	logic [DAYS_WIDTH-1:0] days_s3;
	logic [TOD_WIDTH-1:0]  tod_s3;

	always_comb begin
		dfix_c = (drem_s2 >= DREM_WIDTH'(DAY_ODD_DIV));
		rfix_c = dfix_c ? drem_s2 - DREM_WIDTH'(DAY_ODD_DIV) : drem_s2;
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			days_s3 <= qest_s2 + DAYS_WIDTH'(dfix_c);
			tod_s3  <= {rfix_c[TOD_WIDTH-DAY_LO_BITS-1:0], slo_s2};
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: products for the year estimate and for the hour.
	// ------------------------------------------------------------------
	logic [YEST_PWIDTH-1:0]    yprod_s4;
	logic [DIV3600_PWIDTH-1:0] hprod_s4;
	logic [DAYS_WIDTH-1:0]     days_s4;
	logic [TOD_WIDTH-1:0]      tod_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			yprod_s4 <= YEST_PWIDTH'(days_s3) * YEST_PWIDTH'(YEST_MULT);
			hprod_s4 <= DIV3600_PWIDTH'(tod_s3) * DIV3600_PWIDTH'(DIV3600_MULT);
			days_s4  <= days_s3;
			tod_s4   <= tod_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: the estimate is the floor of days / 365.2425 or one below.
	// The true year lies in the four years that start one below it.
	// The hour is exact; the rest of the hour is kept in seconds.
	// ------------------------------------------------------------------
	logic [YEAR_WIDTH-1:0] yest_c;
	logic [YEAR_WIDTH-1:0] base_c;
	logic [4:0]            hour_c;
	logic [YEAR_WIDTH-1:0] base_s5;
	logic [4:0]            hour_s5;
	logic [RSEC_WIDTH-1:0] rsec_s5;
	logic [DAYS_WIDTH-1:0] days_s5;

	always_comb begin
		yest_c = YEAR_WIDTH'(yprod_s4 >> DAYS_WIDTH);
		base_c = (yest_c == '0) ? '0 : yest_c - YEAR_WIDTH'(1);
		hour_c = 5'(hprod_s4 >> DIV3600_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			base_s5 <= base_c;
			hour_s5 <= hour_c;
			rsec_s5 <= RSEC_WIDTH'(tod_s4) - RSEC_WIDTH'(hour_c) * RSEC_WIDTH'(HOUR_SECS);
			days_s5 <= days_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: century count product for the base year, minute product.
	// ------------------------------------------------------------------
	logic [YOFF_WIDTH-1:0]    yoff_c;
	logic [DIV100_PWIDTH-1:0] cprod_s6;
	logic [YOFF_WIDTH-1:0]    yoff_s6;
	logic [DIV60_PWIDTH-1:0]  mprod_s6;
	logic [YEAR_WIDTH-1:0]    base_s6;
	logic [DAYS_WIDTH-1:0]    days_s6;
	logic [4:0]               hour_s6;
	logic [RSEC_WIDTH-1:0]    rsec_s6;

	assign yoff_c = YOFF_WIDTH'(base_s5) + YOFF_WIDTH'(YEAR_OFFS);

	always_ff @(posedge clk) begin
		if (adv6) begin
			cprod_s6 <= DIV100_PWIDTH'(yoff_c) * DIV100_PWIDTH'(DIV100_MULT);
			yoff_s6  <= yoff_c;
			mprod_s6 <= DIV60_PWIDTH'(rsec_s5) * DIV60_PWIDTH'(DIV60_MULT);
			base_s6  <= base_s5;
			days_s6  <= days_s5;
			hour_s6  <= hour_s5;
			rsec_s6  <= rsec_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: century quotient and remainder, minute and second.
	// ------------------------------------------------------------------
	logic [YOFF_WIDTH-1:0] c0_c;
	logic [5:0]            minute_c;
	logic [YOFF_WIDTH-1:0] c0_s7;
	logic [6:0]            r0_s7;
	logic [5:0]            minute_s7;
	logic [5:0]            second_s7;
	logic [YEAR_WIDTH-1:0] base_s7;
	logic [DAYS_WIDTH-1:0] days_s7;
	logic [4:0]            hour_s7;

	always_comb begin
		c0_c     = YOFF_WIDTH'(cprod_s6 >> DIV100_SHIFT);
		minute_c = 6'(mprod_s6 >> DIV60_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (adv7) begin
			c0_s7     <= c0_c;
			r0_s7     <= 7'(yoff_s6) - 7'(c0_c) * 7'(CENTURY);
			minute_s7 <= minute_c;
			second_s7 <= 6'(rsec_s6) - minute_c * 6'(MIN_SECS);
			base_s7   <= base_s6;
			days_s7   <= days_s6;
			hour_s7   <= hour_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: first-day index and leap flag of the four candidate years.
	// Stepping the century remainder by one per candidate avoids another
	// division: the quotient only moves when the remainder passes 99.
	// ------------------------------------------------------------------
	logic [7:0]            t_c    [NUM_CAND+1];
	logic                  wrap_c [NUM_CAND+1];
	logic [YOFF_WIDTH-1:0] cq_c   [NUM_CAND+1];
	logic [6:0]            rr_c   [NUM_CAND+1];
	logic [YOFF_WIDTH-1:0] yc_c   [NUM_CAND];
	logic [YS_WIDTH-1:0]   ys_c   [NUM_CAND];
	logic [NUM_CAND-1:0]   leap_c;

	logic [YS_WIDTH-1:0]   ys_s8  [NUM_CAND];
	logic [NUM_CAND-1:0]   leap_s8;
	logic [YEAR_WIDTH-1:0] base_s8;
	logic [DAYS_WIDTH-1:0] days_s8;
	logic [4:0]            hour_s8;
	logic [5:0]            minute_s8;
	logic [5:0]            second_s8;

	always_comb begin
		for (int k = 0; k <= NUM_CAND; k++) begin
			t_c[k]    = 8'(r0_s7) + 8'(k);
			wrap_c[k] = (t_c[k] >= 8'(CENTURY));
			cq_c[k]   = c0_s7 + YOFF_WIDTH'(wrap_c[k]);
			rr_c[k]   = wrap_c[k] ? 7'(t_c[k] - 8'(CENTURY)) : 7'(t_c[k]);
		end
		for (int j = 0; j < NUM_CAND; j++) begin
			yc_c[j]   = YOFF_WIDTH'(base_s7) + YOFF_WIDTH'(j);
			ys_c[j]   = YS_WIDTH'(yc_c[j]) * YS_WIDTH'(DAYS_PER_YEAR)
				+ YS_WIDTH'((yc_c[j] + YOFF_WIDTH'(3)) >> 2)
				+ YS_WIDTH'(cq_c[j] >> 2)
				- YS_WIDTH'(cq_c[j]);
			// The full year is divisible by 4 exactly when the offset is.
			leap_c[j] = (yc_c[j][1:0] == 2'd0)
				&& ((rr_c[j+1] != 7'd0) || (cq_c[j+1][1:0] == 2'd0));
		end
	end

	always_ff @(posedge clk) begin
		if (adv8) begin
			ys_s8     <= ys_c;
			leap_s8   <= leap_c;
			base_s8   <= base_s7;
			days_s8   <= days_s7;
			hour_s8   <= hour_s7;
			minute_s8 <= minute_s7;
			second_s8 <= second_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: the year is the last candidate that starts on or before
	// the day count; first-day indexes grow with the year.
	// ------------------------------------------------------------------
	logic [1:0]                cnt_c;
	logic [YOFF_WIDTH-1:0]     yfull_c;
	logic [YEAR_OUT_WIDTH-1:0] year_s9;
	logic [DOY_WIDTH-1:0]      doy_s9;
	logic                      leap_s9;
	logic [4:0]                hour_s9;
	logic [5:0]                minute_s9;
	logic [5:0]                second_s9;

	always_comb begin
		cnt_c = 2'(ys_s8[1] <= YS_WIDTH'(days_s8))
			+ 2'(ys_s8[2] <= YS_WIDTH'(days_s8))
			+ 2'(ys_s8[3] <= YS_WIDTH'(days_s8));
		yfull_c = YOFF_WIDTH'(base_s8) + YOFF_WIDTH'(cnt_c);
	end

	always_ff @(posedge clk) begin
		if (adv9) begin
			year_s9   <= YEAR_OUT_WIDTH'(YEAR_BASE) + YEAR_OUT_WIDTH'(yfull_c);
			doy_s9    <= DOY_WIDTH'(YS_WIDTH'(days_s8) - ys_s8[cnt_c]);
			leap_s9   <= leap_s8[cnt_c];
			hour_s9   <= hour_s8;
			minute_s9 <= minute_s8;
			second_s9 <= second_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: month search over the cumulative table, then the output
	// register. The month is the last table entry not above the day index.
	// ------------------------------------------------------------------
	logic [3:0]                mi_c;
	logic [YEAR_OUT_WIDTH-1:0] year_s10;
	logic [3:0]                month_s10;
	logic [4:0]                dom_s10;
	logic [4:0]                hour_s10;
	logic [5:0]                minute_s10;
	logic [5:0]                second_s10;

	always_comb begin
		mi_c = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (cum_days(leap_s9, 4'(k)) <= doy_s9) begin
				mi_c = 4'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv10) begin
			year_s10   <= year_s9;
			month_s10  <= mi_c + 4'd1;
			dom_s10    <= 5'(doy_s9 - cum_days(leap_s9, mi_c) + DOY_WIDTH'(1));
			hour_s10   <= hour_s9;
			minute_s10 <= minute_s9;
			second_s10 <= second_s9;
		end
	end

	assign out_valid    = v_s10;
	assign year         = year_s10;
	assign month        = month_s10;
	assign day_of_month = dom_s10;
	assign hour         = hour_s10;
	assign minute       = minute_s10;
	assign second       = second_s10;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// The reciprocal estimate of the day count is off by at most one.
	a_day_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (drem_s2 < DREM_WIDTH'(2 * DAY_ODD_DIV)))
		else $error("day remainder out of range");

	// The century division is exact.
	a_century_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (r0_s7 < 7'(CENTURY)))
		else $error("century remainder out of range");

	// The lowest candidate year never starts after the day count.
	a_year_window: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (ys_s8[0] <= YS_WIDTH'(days_s8)))
		else $error("year estimate too high");

	// An accepted beat shows up in the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted beat lost at entry");

	// Delivered fields stay in their calendar ranges.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1) && (month <= 4'd12)
			&& (day_of_month >= 5'd1) && (hour <= 5'd23)
			&& (minute <= 6'd59) && (second <= 6'd59))
		else $error("result field out of range");

endmodule
`default_nettype wire
